FILE: rtl/agc_pkg.sv
// Package for the AGAST 5_8 corner test: shared types, register codes and
// the two decision trees as functions. No dependencies.
package agc_pkg;

    localparam int unsigned NUM_LANES = 8;
    localparam int unsigned PIX_W     = 8;

    // Register indexes on the configuration port (taken from paddr[2]).
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_MASK_LIMIT = 1'b1;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET  = 8'd10;
    localparam logic [PIX_W-1:0] MASK_LIMIT_RESET = 8'd20;

    // Tree result codes: bit 1 is the corner flag, bit 0 the next mode.
    localparam logic [1:0] RES_H  = 2'b00;
    localparam logic [1:0] RES_S  = 2'b01;
    localparam logic [1:0] RES_CH = 2'b10;
    localparam logic [1:0] RES_CS = 2'b11;

    localparam logic MODE_HOMOGENEOUS = 1'b0;

    typedef struct packed {
        logic [NUM_LANES-1:0] bright;
        logic [NUM_LANES-1:0] dark;
    } agc_class_t;

    typedef struct packed {
        logic corner;
        logic mode;
    } agc_result_t;

    function automatic logic [1:0] tail_test(input logic [7:0] m);
        if (!(m[3] && m[5])) return RES_H;
        if (m[2]) begin
            if (m[1]) return m[4] ? RES_CH : RES_H;
            if (m[4]) return m[6] ? RES_CH : RES_H;
            return RES_H;
        end
        if (m[7]) return (m[4] && m[6]) ? RES_CH : RES_H;
        return RES_H;
    endfunction

    function automatic logic [1:0] tree_homogeneous(input logic [7:0] b, input logic [7:0] d);
        if (b[0]) begin
            if (b[2]) begin
                if (b[3]) begin
                    if (b[5]) begin
                        if (b[1]) return (b[4] || b[7]) ? RES_CS : RES_H;
                        if (b[4]) return b[6] ? RES_CS : RES_H;
                        return RES_H;
                    end
                    if (b[1]) return (b[4] || b[7]) ? RES_CH : RES_H;
                    return RES_H;
                end
                if (b[7]) begin
                    if (!b[6]) return RES_H;
                    if (b[5]) return (b[1] || b[4]) ? RES_CS : RES_H;
                    return b[1] ? RES_CH : RES_H;
                end
                if (d[5] && d[3] && d[7] && d[4]) return d[6] ? RES_CS : RES_S;
                return RES_H;
            end
            if (b[5]) begin
                if (b[7] && b[6]) return (b[1] || b[4]) ? RES_CH : RES_H;
                return RES_H;
            end
            if (d[5]) begin
                if (!d[3]) return RES_H;
                if (d[2]) begin
                    if (d[1]) return d[4] ? RES_CS : RES_H;
                    if (d[4]) return d[6] ? RES_CS : RES_H;
                    return RES_H;
                end
                if (d[7] && d[4]) return d[6] ? RES_CS : RES_H;
                return RES_H;
            end
            return RES_H;
        end
        if (d[0]) begin
            if (d[2]) begin
                if (b[7]) begin
                    if (d[3]) begin
                        if (d[5]) begin
                            if (d[1]) return d[4] ? RES_CS : RES_S;
                            if (d[4]) return d[6] ? RES_CS : RES_S;
                            return RES_H;
                        end
                        if (d[1]) return d[4] ? RES_CS : RES_H;
                        return RES_H;
                    end
                    if (b[5] && b[3] && b[4]) return b[6] ? RES_CS : RES_S;
                    return RES_H;
                end
                if (d[7]) begin
                    if (d[3]) begin
                        if (d[5]) begin
                            if (d[1]) return RES_CS;
                            if (d[4]) return d[6] ? RES_CS : RES_S;
                            return RES_H;
                        end
                        return d[1] ? RES_CH : RES_H;
                    end
                    if (d[6]) begin
                        if (d[5]) return (d[1] || d[4]) ? RES_CS : RES_H;
                        return d[1] ? RES_CH : RES_H;
                    end
                    return RES_H;
                end
                if (d[3]) begin
                    if (d[5]) begin
                        if (d[1]) return d[4] ? RES_CS : RES_H;
                        if (d[4]) return d[6] ? RES_CS : RES_H;
                        return RES_H;
                    end
                    if (d[1]) return d[4] ? RES_CH : RES_H;
                    return RES_H;
                end
                return RES_H;
            end
            if (b[5]) begin
                if (!b[3]) return RES_H;
                if (b[2]) begin
                    if (b[1]) return b[4] ? RES_CS : RES_H;
                    if (b[4]) return b[6] ? RES_CS : RES_H;
                    return RES_H;
                end
                if (b[7] && b[4]) return b[6] ? RES_CS : RES_H;
                return RES_H;
            end
            if (d[5]) begin
                if (d[7] && d[6]) return (d[1] || d[4]) ? RES_CH : RES_H;
                return RES_H;
            end
            return RES_H;
        end
        if (b[3]) return tail_test(b);
        if (d[3]) return tail_test(d);
        return RES_H;
    endfunction

    function automatic logic [1:0] tree_structured(input logic [7:0] b, input logic [7:0] d);
        if (b[0]) begin
            if (b[2]) begin
                if (b[3]) begin
                    if (b[5]) begin
                        if (b[7]) begin
                            if (b[1]) return RES_CS;
                            if (b[4]) return b[6] ? RES_CS : RES_S;
                            return RES_S;
                        end
                        if (b[1]) return b[4] ? RES_CS : RES_S;
                        if (b[4]) return b[6] ? RES_CS : RES_S;
                        return RES_S;
                    end
                    if (b[7]) return b[1] ? RES_CS : RES_S;
                    if (b[1]) return b[4] ? RES_CS : RES_S;
                    return RES_S;
                end
                if (b[7]) begin
                    if (!b[6]) return RES_S;
                    if (b[5]) return (b[1] || b[4]) ? RES_CS : RES_S;
                    return b[1] ? RES_CS : RES_S;
                end
                if (d[5]) begin
                    if (!(d[3] && d[7])) return RES_H;
                    if (d[4]) return d[6] ? RES_CS : RES_S;
                    return RES_S;
                end
                return RES_S;
            end
            if (b[5]) begin
                if (b[7] && b[6]) return (b[1] || b[4]) ? RES_CS : RES_S;
                return RES_S;
            end
            if (d[5]) begin
                if (!d[3]) return RES_S;
                if (d[2]) begin
                    if (d[1]) return d[4] ? RES_CS : RES_S;
                    if (d[4]) return d[6] ? RES_CS : RES_S;
                    return RES_S;
                end
                if (d[7] && d[4]) return d[6] ? RES_CH : RES_H;
                return RES_H;
            end
            return RES_H;
        end
        if (d[0]) begin
            if (d[2]) begin
                if (b[7]) begin
                    if (d[3]) begin
                        if (d[5]) begin
                            if (d[1]) return d[4] ? RES_CS : RES_S;
                            if (d[4]) return d[6] ? RES_CS : RES_S;
                            return RES_S;
                        end
                        if (d[1]) return d[4] ? RES_CS : RES_S;
                        return RES_S;
                    end
                    if (b[5]) begin
                        if (!b[3]) return RES_H;
                        if (b[4]) return b[6] ? RES_CS : RES_S;
                        return RES_S;
                    end
                    return RES_S;
                end
                if (d[7]) begin
                    if (d[3]) begin
                        if (d[5]) begin
                            if (d[1]) return RES_CS;
                            if (d[4]) return d[6] ? RES_CS : RES_S;
                            return RES_S;
                        end
                        return d[1] ? RES_CS : RES_S;
                    end
                    if (d[6]) begin
                        if (d[5]) return (d[1] || d[4]) ? RES_CS : RES_S;
                        return d[1] ? RES_CS : RES_S;
                    end
                    return RES_S;
                end
                if (d[3]) begin
                    if (d[5]) begin
                        if (d[1]) return d[4] ? RES_CH : RES_H;
                        if (d[4]) return d[6] ? RES_CH : RES_H;
                        return RES_H;
                    end
                    if (d[1]) return d[4] ? RES_CH : RES_H;
                    return RES_H;
                end
                return RES_H;
            end
            if (b[5]) begin
                if (!b[3]) return RES_S;
                if (b[2]) begin
                    if (b[1]) return b[4] ? RES_CS : RES_S;
                    if (b[4]) return b[6] ? RES_CS : RES_S;
                    return RES_S;
                end
                if (b[7] && b[4]) return b[6] ? RES_CH : RES_H;
                return RES_H;
            end
            if (d[5]) begin
                if (d[7] && d[6]) return (d[1] || d[4]) ? RES_CS : RES_S;
                return RES_S;
            end
            return RES_H;
        end
        if (b[3]) return tail_test(b);
        if (d[3]) return tail_test(d);
        return RES_H;
    endfunction

endpackage

FILE: rtl/agc_lane.sv
// One comparison lane: classes a single ring neighbour as brighter or darker
// than the centre by more than the threshold. Depends on agc_pkg.
module agc_lane
    import agc_pkg::*;
(
    input  logic [PIX_W-1:0] pixel,
    input  logic [PIX_W-1:0] centre,
    input  logic [PIX_W-1:0] threshold,
    output logic             bright,
    output logic             dark
);

    logic [PIX_W:0] hi_sum;
    logic [PIX_W:0] pix_plus;

    // The sums carry one extra bit so that they never wrap; pixel < centre - t
    // is tested as pixel + t < centre to stay unsigned.
    assign hi_sum   = {1'b0, centre} + {1'b0, threshold};
    assign pix_plus = {1'b0, pixel} + {1'b0, threshold};
    assign bright   = {1'b0, pixel} > hi_sum;
    assign dark     = pix_plus < {1'b0, centre};

endmodule

FILE: rtl/agc_merge.sv
// Merging stage: combines the lane classes through the tree picked by the
// current mode, and applies the mask skip. Depends on agc_pkg.
module agc_merge
    import agc_pkg::*;
(
    input  agc_class_t  classes,
    input  logic        mode,
    input  logic        skip,
    output agc_result_t result
);

    logic [1:0] homog_code;
    logic [1:0] struct_code;
    logic [1:0] code;

    assign homog_code  = tree_homogeneous(classes.bright, classes.dark);
    assign struct_code = tree_structured(classes.bright, classes.dark);

    always_comb
    begin
        if (skip)
        begin
            code = RES_H;
        end
        else if (mode == MODE_HOMOGENEOUS)
        begin
            code = homog_code;
        end
        else
        begin
            code = struct_code;
        end
    end

    assign result.corner = code[1];
    assign result.mode   = code[0];

endmodule

FILE: rtl/agast_5_8_corner_test.sv
// AGAST 5_8 corner test, top level: configuration registers, eight comparison
// lanes, the merging tree stage, the scan mode register and the output register.
// An accepted item's result is held in the output register from the next cycle on.
// One item per cycle unless the output stalls; the scan mode loop closes per item.
// Reset (rst_n, asynchronous): threshold 10, mask limit 20, mode homogeneous,
// output empty. Depends on agc_pkg, agc_lane and agc_merge.
module agast_5_8_corner_test
    import agc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  centre_pixel,
    input  logic [7:0]  neighbour_0,
    input  logic [7:0]  neighbour_1,
    input  logic [7:0]  neighbour_2,
    input  logic [7:0]  neighbour_3,
    input  logic [7:0]  neighbour_4,
    input  logic [7:0]  neighbour_5,
    input  logic [7:0]  neighbour_6,
    input  logic [7:0]  neighbour_7,
    input  logic [7:0]  mask_value,
    input  logic        row_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_corner,
    output logic        mode_after
);

    logic [PIX_W-1:0] threshold_reg;
    logic [PIX_W-1:0] mask_limit_reg;
    logic             scan_mode_reg;
    logic             out_valid_reg;
    logic             is_corner_reg;
    logic             mode_after_reg;

    logic [PIX_W-1:0] neighbours [NUM_LANES];
    agc_class_t       classes;
    agc_result_t      result;
    logic             cfg_write;
    logic             in_accept;
    logic             skip;
    logic             mode_now;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            mask_limit_reg <= MASK_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_THRESHOLD)
            begin
                threshold_reg <= pwdata[PIX_W-1:0];
            end
            else
            begin
                mask_limit_reg <= pwdata[PIX_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_THRESHOLD:  prdata = {24'd0, threshold_reg};
            REG_MASK_LIMIT: prdata = {24'd0, mask_limit_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign neighbours[0] = neighbour_0;
    assign neighbours[1] = neighbour_1;
    assign neighbours[2] = neighbour_2;
    assign neighbours[3] = neighbour_3;
    assign neighbours[4] = neighbour_4;
    assign neighbours[5] = neighbour_5;
    assign neighbours[6] = neighbour_6;
    assign neighbours[7] = neighbour_7;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        agc_lane u_lane (
            .pixel     (neighbours[g]),
            .centre    (centre_pixel),
            .threshold (threshold_reg),
            .bright    (classes.bright[g]),
            .dark      (classes.dark[g])
        );
    end

    // A row start forces the homogeneous tree for this item.
    assign mode_now = row_start ? MODE_HOMOGENEOUS : scan_mode_reg;
    assign skip     = mask_value < mask_limit_reg;

    agc_merge u_merge (
        .classes (classes),
        .mode    (mode_now),
        .skip    (skip),
        .result  (result)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg <= MODE_HOMOGENEOUS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                scan_mode_reg <= result.mode;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            is_corner_reg  <= result.corner;
            mode_after_reg <= result.mode;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_corner  = is_corner_reg;
    assign mode_after = mode_after_reg;

    // A masked item leaves no corner and the homogeneous mode.
    a_masked_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && skip |=> out_valid && !is_corner && !mode_after && !scan_mode_reg)
        else $error("masked item did not clear corner and mode");

    // The reported next mode is the one held for the following item.
    a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> mode_after == scan_mode_reg)
        else $error("mode_after differs from the stored scan mode");

    // While a result is stalled no item is taken, so the mode holds.
    a_stall_holds_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(scan_mode_reg))
        else $error("scan mode changed while the output was stalled");

endmodule
